### rtl/cgp_pkg.sv
// ----------------------------------------------------------------------------
// cgp_pkg
// shared types, register indexes and the cordic arctangent table
// ----------------------------------------------------------------------------
package cgp_pkg;

  localparam int unsigned PIX_W      = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CW         = 34;  // cordic x/y datapath width
  localparam int unsigned ZW         = 32;  // turn accumulator width
  localparam int unsigned CORDIC_N   = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_ANGLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 3'd5;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] weight;
  } pix_out_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
    logic                 zero;   // vector of length zero, angle forced to 0
  } cordic_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [ZW-1:0] atan_turn(input int unsigned i);
    logic [ZW-1:0] r;
    unique case (i)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      24: r = 32'h00000029;  25: r = 32'h00000014;  26: r = 32'h0000000A;
      27: r = 32'h00000005;  28: r = 32'h00000003;  29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### rtl/cgp_norm.sv
// ----------------------------------------------------------------------------
// cgp_norm
// offset from centre, normalizing shift and half-plane fold (two stages)
// ----------------------------------------------------------------------------
module cgp_norm import cgp_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  pix_in_t         pix_i,
  input  logic [15:0]     center_x_i,
  input  logic [15:0]     center_y_i,
  output logic            valid_o,
  output cordic_t         vec_o
);

  localparam logic [PIX_W-1:0] CMASK =
    (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << COORD_BITS) - 1);

  logic [PIX_W-1:0]   px, py;
  logic signed [17:0] dx_d, dy_d, dx_q, dy_q;
  logic [17:0]        ax, ay;
  logic [16:0]        m;
  logic [4:0]         msb;
  logic [4:0]         sh_d, sh_q;
  logic               zero_d, zero_q, v1_q;
  logic signed [CW-1:0] xe, ye, xs, ys;
  cordic_t            vec_d;

  // stage 1: offset and shift amount
  always_comb begin
    px     = pix_i.pixel_x & CMASK;
    py     = pix_i.pixel_y & CMASK;
    dx_d   = $signed({2'b00, px, 4'h8}) - $signed({2'b00, center_x_i});
    dy_d   = $signed({2'b00, py, 4'h8}) - $signed({2'b00, center_y_i});
    ax     = dx_d[17] ? 18'(-dx_d) : 18'(dx_d);
    ay     = dy_d[17] ? 18'(-dy_d) : 18'(dy_d);
    m      = ax[16:0] | ay[16:0];
    msb    = '0;
    for (int i = 0; i < 17; i++) begin
      if (m[i]) msb = 5'(i);
    end
    sh_d   = 5'(29) - msb;
    zero_d = (m == '0);
  end

  // stage 2: normalize and fold the left half-plane
  always_comb begin
    xe = CW'(dx_q);
    ye = CW'(dy_q);
    xs = xe <<< sh_q;
    ys = ye <<< sh_q;
    vec_d.zero = zero_q;
    if (xs[CW-1]) begin
      vec_d.x = -xs;
      vec_d.y = -ys;
      vec_d.z = 32'h80000000;
    end else begin
      vec_d.x = xs;
      vec_d.y = ys;
      vec_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      sh_q   <= sh_d;
      zero_q <= zero_d;
      vec_o  <= vec_d;
    end
  end

endmodule

### rtl/cgp_cordic_stage.sv
// ----------------------------------------------------------------------------
// cgp_cordic_stage
// one registered cordic vectoring micro-rotation
// ----------------------------------------------------------------------------
module cgp_cordic_stage import cgp_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  cordic_t vec_i,
  output logic    valid_o,
  output cordic_t vec_o
);

  localparam logic [ZW-1:0] ATAN = atan_turn(IDX);

  logic signed [CW-1:0] xs, ys;
  cordic_t vec_d;

  always_comb begin
    xs = vec_i.x >>> IDX;
    ys = vec_i.y >>> IDX;
    vec_d.zero = vec_i.zero;
    if (!vec_i.y[CW-1]) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + ATAN;
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) vec_o <= vec_d;
  end

endmodule

### rtl/cgp_phase.sv
// ----------------------------------------------------------------------------
// cgp_phase
// angle rounding, phase against the arc, and divider operand setup
// ----------------------------------------------------------------------------
module cgp_phase import cgp_pkg::*; #(
  parameter int unsigned ANGLE_BITS = 16,
  localparam int unsigned NW = ANGLE_BITS + 10,
  localparam int unsigned DW = ANGLE_BITS + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  cordic_t           vec_i,
  input  logic [15:0]       start_angle_i,
  input  logic signed [17:0] sweep_i,
  output logic              valid_o,
  output logic [NW-1:0]     n_o,
  output logic [DW-1:0]     d_o,
  output logic [7:0]        q_o,
  output logic              byp_o
);

  localparam int unsigned A  = ANGLE_BITS;
  localparam int unsigned MW = (A + 1 > 18) ? A + 1 : 18;
  localparam logic [ZW-1:0] RND    = ZW'(1) << (31 - A);
  localparam logic [MW-1:0] TURN_M = MW'(1) << A;
  localparam logic [A:0]    TURN   = (A + 1)'(1) << A;

  logic [ZW-1:0] zr;
  logic [A-1:0]  ang, st, diff, phase_d, phase_q;
  logic [17:0]   smag;
  logic [MW-1:0] magw;
  logic [A:0]    mag_d, mag_q;
  logic          v1_q;

  logic [A:0]    ph1, ds, ed, de;
  logic [NW-1:0] pn;
  logic [NW-1:0] n_d;
  logic [DW-1:0] d_d;
  logic [7:0]    q_d;
  logic          byp_d;

  // stage 1: rounded angle, phase, saturated sweep magnitude
  always_comb begin
    zr      = vec_i.z + RND;
    ang     = vec_i.zero ? '0 : zr[ZW-1 -: A];
    st      = A'(start_angle_i);
    diff    = ang - st;
    phase_d = sweep_i[17] ? A'('0 - diff) : diff;
    smag    = sweep_i[17] ? 18'(-sweep_i) : 18'(sweep_i);
    magw    = MW'(smag);
    mag_d   = (magw > TURN_M) ? TURN : magw[A:0];
  end

  // stage 2: a zero sweep gives 0, inside the arc goes to the divider, outside snaps to an end
  always_comb begin
    ph1   = {1'b0, phase_q};
    pn    = NW'(phase_q);
    n_d   = '0;
    d_d   = '0;
    q_d   = '0;
    byp_d = 1'b1;
    ds    = (ph1 < TURN - ph1) ? ph1 : TURN - ph1;
    ed    = ph1 - mag_q;
    de    = (ed < TURN - ed) ? ed : TURN - ed;
    priority if (mag_q == '0) begin
      q_d = 8'd0;
    end else if (ph1 <= mag_q) begin
      // round(phase*255/mag) = (510*phase + mag) / (2*mag)
      n_d   = (pn << 9) - (pn << 1) + NW'(mag_q);
      d_d   = {mag_q, 1'b0};
      byp_d = 1'b0;
    end else begin
      q_d = (ds <= de) ? 8'd0 : 8'd255;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phase_q <= phase_d;
      mag_q   <= mag_d;
      n_o     <= n_d;
      d_o     <= d_d;
      q_o     <= q_d;
      byp_o   <= byp_d;
    end
  end

endmodule

### rtl/cgp_div_stage.sv
// ----------------------------------------------------------------------------
// cgp_div_stage
// one quotient bit of the pipelined restoring divider
// ----------------------------------------------------------------------------
module cgp_div_stage #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned IDX        = 0,
  localparam int unsigned NW = ANGLE_BITS + 10,
  localparam int unsigned DW = ANGLE_BITS + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  input  logic [7:0]    q_i,
  input  logic          byp_i,
  output logic          valid_o,
  output logic [NW-1:0] n_o,
  output logic [DW-1:0] d_o,
  output logic [7:0]    q_o,
  output logic          byp_o
);

  logic [NW-1:0] dk, n_d;
  logic [7:0]    q_d;

  always_comb begin
    dk  = NW'(d_i) << IDX;
    n_d = n_i;
    q_d = q_i;
    if (!byp_i && n_i >= dk) begin
      n_d      = n_i - dk;
      q_d[IDX] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o   <= n_d;
      d_o   <= d_i;
      q_o   <= q_d;
      byp_o <= byp_i;
    end
  end

endmodule

### rtl/cgp_blend.sv
// ----------------------------------------------------------------------------
// cgp_blend
// start/end colour mix by the weight; second register is the output word
// ----------------------------------------------------------------------------
module cgp_blend import cgp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [7:0]  w_i,
  input  logic [23:0] start_color_i,
  input  logic [23:0] end_color_i,
  output logic        valid_o,
  output pix_out_t    pix_o
);

  logic [8:0]         a;
  logic signed [8:0]  dif  [3];
  logic signed [18:0] prod_d [3];
  logic signed [18:0] prod_q [3];
  logic [7:0]         s_q  [3];
  logic [7:0]         w_q;
  logic signed [18:0] sh   [3];
  logic [7:0]         c    [3];
  logic               v1_q;
  pix_out_t           pix_d;

  always_comb begin
    a = {1'b0, w_i} + {8'b0, w_i[7]};
    for (int k = 0; k < 3; k++) begin
      dif[k]    = $signed({1'b0, end_color_i[8*k +: 8]})
                - $signed({1'b0, start_color_i[8*k +: 8]});
      prod_d[k] = 19'($signed({1'b0, a})) * 19'(dif[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sh[k] = prod_q[k] >>> 8;
      c[k]  = s_q[k] + sh[k][7:0];
    end
    pix_d.blue   = c[0];
    pix_d.green  = c[1];
    pix_d.red    = c[2];
    pix_d.weight = w_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= prod_d[k];
        s_q[k]    <= start_color_i[8*k +: 8];
      end
      w_q   <= w_i;
      pix_o <= pix_d;
    end
  end

endmodule

### rtl/conic_gradient_pixel_core.sv
// ----------------------------------------------------------------------------
// conic_gradient_pixel_core
// conic gradient colour, unless stalled, for one pixel per clock
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while the output is not stalled and returns
// its blended colour and weight in order, one result word per pixel. The
// pipeline holds two stages of centre offset and normalization, 32 cordic
// vectoring stages (one micro-rotation each), two stages of phase and arc
// classification, eight stages of a restoring divider (one quotient bit each)
// and two blend stages, the last of which is the output register. The whole
// pipeline advances together whenever the output word is taken or the output
// register is empty, so in_ready_o is high exactly then and a stalled output
// holds every stage in place. Configuration registers are read directly by
// the stages and must only change while no pixel is in flight.
// ----------------------------------------------------------------------------
module conic_gradient_pixel_core import cgp_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel in
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,
  // colour out
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_out_t              out_data_o,
  // register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NW = ANGLE_BITS + 10;
  localparam int unsigned DW = ANGLE_BITS + 2;
  localparam int unsigned DIV_N = 8;

  // configuration registers
  logic [15:0]        center_x_q, center_y_q, start_angle_q;
  logic signed [17:0] sweep_q;
  logic [23:0]        start_color_q, end_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= '0;
      center_y_q    <= '0;
      start_angle_q <= '0;
      sweep_q       <= 18'sh10000;       // one full turn
      start_color_q <= '0;
      end_color_q   <= 24'hFFFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_X:    center_x_q    <= cfg_data_i[15:0];
        REG_CENTER_Y:    center_y_q    <= cfg_data_i[15:0];
        REG_START_ANGLE: start_angle_q <= cfg_data_i[15:0];
        REG_SWEEP_ANGLE: sweep_q       <= $signed(cfg_data_i[17:0]);
        REG_START_COLOR: start_color_q <= cfg_data_i;
        REG_END_COLOR:   end_color_q   <= cfg_data_i;
        default: ;                       // unused index, write dropped
      endcase
    end
  end

  // global pipeline advance
  logic en;
  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  // normalization
  cordic_t cv  [CORDIC_N+1];
  logic    cvv [CORDIC_N+1];

  cgp_norm #(.COORD_BITS(COORD_BITS)) u_norm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .pix_i      (in_data_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .valid_o    (cvv[0]),
    .vec_o      (cv[0])
  );

  // cordic vectoring chain, one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
    cgp_cordic_stage #(.IDX(i)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cvv[i]),
      .vec_i   (cv[i]),
      .valid_o (cvv[i+1]),
      .vec_o   (cv[i+1])
    );
  end

  // phase and divider setup
  logic [NW-1:0] dn  [DIV_N+1];
  logic [DW-1:0] dd  [DIV_N+1];
  logic [7:0]    dq  [DIV_N+1];
  logic          db  [DIV_N+1];
  logic          dv  [DIV_N+1];

  cgp_phase #(.ANGLE_BITS(ANGLE_BITS)) u_phase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (cvv[CORDIC_N]),
    .vec_i         (cv[CORDIC_N]),
    .start_angle_i (start_angle_q),
    .sweep_i       (sweep_q),
    .valid_o       (dv[0]),
    .n_o           (dn[0]),
    .d_o           (dd[0]),
    .q_o           (dq[0]),
    .byp_o         (db[0])
  );

  // divider, most significant quotient bit first
  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    cgp_div_stage #(.ANGLE_BITS(ANGLE_BITS), .IDX(DIV_N - 1 - j)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[j]),
      .n_i     (dn[j]),
      .d_i     (dd[j]),
      .q_i     (dq[j]),
      .byp_i   (db[j]),
      .valid_o (dv[j+1]),
      .n_o     (dn[j+1]),
      .d_o     (dd[j+1]),
      .q_o     (dq[j+1]),
      .byp_o   (db[j+1])
    );
  end

  // colour mix and output register
  cgp_blend u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (dv[DIV_N]),
    .w_i           (dq[DIV_N]),
    .start_color_i (start_color_q),
    .end_color_i   (end_color_q),
    .valid_o       (out_valid_o),
    .pix_o         (out_data_o)
  );

  // zero sweep always gives the start colour end of the ramp
  a_zero_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sweep_q == '0 |-> out_data_o.weight == 8'd0)
    else $error("nonzero weight with zero sweep");

  // weight 255 reproduces the end colour exactly
  a_full_weight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.weight == 8'd255 |->
      out_data_o.red == end_color_q[23:16] && out_data_o.green == end_color_q[15:8]
      && out_data_o.blue == end_color_q[7:0])
    else $error("weight 255 does not give end colour");

  // weight 0 reproduces the start colour exactly
  a_zero_weight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.weight == 8'd0 |->
      out_data_o.red == start_color_q[23:16] && out_data_o.green == start_color_q[15:8]
      && out_data_o.blue == start_color_q[7:0])
    else $error("weight 0 does not give start colour");

endmodule
